// ===== src/tpsq_pkg.sv =====
// shared types and constants for the two-priority send queue
// no dependencies; imported by tpsq_policy and the top level

package tpsq_pkg;

  // queue depths and the widths that follow from them
  localparam int HIGH_DEPTH = 128;
  localparam int LOW_DEPTH  = 256;
  localparam int HIGH_AW    = $clog2(HIGH_DEPTH);
  localparam int LOW_AW     = $clog2(LOW_DEPTH);
  localparam int HIGH_CW    = $clog2(HIGH_DEPTH + 1);
  localparam int LOW_CW     = $clog2(LOW_DEPTH + 1);

  // field widths
  localparam int KIND_W   = 3;
  localparam int HANDLE_W = 16;
  localparam int LENGTH_W = 10;
  localparam int BYTES_W  = 16;
  localparam int TIME_W   = 32;
  localparam int DELAY_W  = 8;
  localparam int LEAK_W   = 12;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 16;
  localparam int HCOUNT_W = 8;
  localparam int LCOUNT_W = 9;
  localparam int ENTRY_W  = HANDLE_W + LENGTH_W;

  // input item kinds
  localparam logic [KIND_W-1:0] KIND_TICK     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ENQ_HIGH = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ENQ_LOW  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUICK    = 3'd4;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_AUX_LIMIT   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_LOW_LIMIT   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_QUICK_LIMIT = 3'd2;
  localparam logic [CFG_IW-1:0] REG_HIGH_DELAY  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_LOW_DELAY   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_LEAK_BYTES  = 3'd5;

  // register reset values
  localparam logic [BYTES_W-1:0] AUX_LIMIT_RST   = 16'd400;
  localparam logic [BYTES_W-1:0] LOW_LIMIT_RST   = 16'd200;
  localparam logic [BYTES_W-1:0] QUICK_LIMIT_RST = 16'd300;
  localparam logic [DELAY_W-1:0] HIGH_DELAY_RST  = 8'd1;
  localparam logic [DELAY_W-1:0] LOW_DELAY_RST   = 8'd2;
  localparam logic [LEAK_W-1:0]  LEAK_BYTES_RST  = 12'd75;

  // minimum seconds between two leaks
  localparam logic [TIME_W-1:0] LEAK_PERIOD = 32'd2;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [LENGTH_W-1:0] length;
  } tpsq_entry_t;

  typedef struct packed {
    logic [BYTES_W-1:0] aux_limit;
    logic [BYTES_W-1:0] low_limit;
    logic [BYTES_W-1:0] quick_limit;
    logic [DELAY_W-1:0] high_delay;
    logic [DELAY_W-1:0] low_delay;
    logic [LEAK_W-1:0]  leak_bytes;
  } tpsq_cfg_t;

  typedef struct packed {
    logic [HIGH_AW-1:0] high_head;
    logic [HIGH_CW-1:0] high_fill;
    logic [LOW_AW-1:0]  low_head;
    logic [LOW_CW-1:0]  low_fill;
    logic [BYTES_W-1:0] sent_bytes;
    logic [TIME_W-1:0]  leak_time;
    logic [TIME_W-1:0]  last_send_time;
    logic [TIME_W-1:0]  now_seconds;
  } tpsq_state_t;

  typedef struct packed {
    logic               high_we;
    logic [HIGH_AW-1:0] high_addr;
    logic               low_we;
    logic [LOW_AW-1:0]  low_addr;
    tpsq_entry_t        data;
  } tpsq_wr_t;

  typedef struct packed {
    logic                sent_valid;
    logic [HANDLE_W-1:0] sent_handle;
    logic [LENGTH_W-1:0] sent_length;
    logic                dropped;
    logic [HCOUNT_W-1:0] high_count;
    logic [LCOUNT_W-1:0] low_count;
    logic [BYTES_W-1:0]  byte_count;
  } tpsq_result_t;

endpackage

// ===== src/tpsq_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module tpsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port, read-first
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/tpsq_policy.sv =====
// per-item decision logic: tick, queue pushes, leak, pop selection, quick send
// depends on tpsq_pkg

module tpsq_policy import tpsq_pkg::*; (
  input  logic [KIND_W-1:0]   kind,
  input  logic [HANDLE_W-1:0] msg_handle,
  input  logic [LENGTH_W-1:0] msg_length,
  input  tpsq_cfg_t           cfg,
  input  tpsq_state_t         cur,
  input  tpsq_entry_t         high_head_data,
  input  tpsq_entry_t         low_head_data,
  output tpsq_state_t         nxt,
  output tpsq_wr_t            wr,
  output tpsq_result_t        res
);

  logic [HIGH_AW:0]   high_pos_sum;
  logic [HIGH_AW-1:0] high_tail;
  logic [LOW_AW:0]    low_pos_sum;
  logic [LOW_AW-1:0]  low_tail;
  logic               high_full;
  logic               low_full;
  logic [TIME_W-1:0]  leak_elapsed;
  logic [TIME_W-1:0]  send_elapsed;
  logic [BYTES_W-1:0] leaked_bytes;
  logic [BYTES_W:0]   bytes_sum;
  logic               pop_send;
  tpsq_entry_t        pop_entry;

  // tail positions and full flags of both rings
  always_comb begin
    high_pos_sum = (HIGH_AW+1)'(cur.high_head) + (HIGH_AW+1)'(cur.high_fill);
    if (high_pos_sum >= (HIGH_AW+1)'(HIGH_DEPTH)) begin
      high_tail = HIGH_AW'(high_pos_sum - (HIGH_AW+1)'(HIGH_DEPTH));
    end else begin
      high_tail = HIGH_AW'(high_pos_sum);
    end
    low_pos_sum = (LOW_AW+1)'(cur.low_head) + (LOW_AW+1)'(cur.low_fill);
    if (low_pos_sum >= (LOW_AW+1)'(LOW_DEPTH)) begin
      low_tail = LOW_AW'(low_pos_sum - (LOW_AW+1)'(LOW_DEPTH));
    end else begin
      low_tail = LOW_AW'(low_pos_sum);
    end
    high_full = (cur.high_fill == HIGH_CW'(HIGH_DEPTH));
    low_full  = (cur.low_fill == LOW_CW'(LOW_DEPTH));
  end

  // leak and pop selection
  always_comb begin
    leak_elapsed = cur.now_seconds - cur.leak_time;
    send_elapsed = cur.now_seconds - cur.last_send_time;
    leaked_bytes = cur.sent_bytes;
    if (leak_elapsed >= LEAK_PERIOD && cur.sent_bytes >= BYTES_W'(cfg.leak_bytes)) begin
      leaked_bytes = cur.sent_bytes - BYTES_W'(cfg.leak_bytes);
    end
    pop_send  = 1'b0;
    pop_entry = high_head_data;
    if (leaked_bytes <= cfg.aux_limit) begin
      if (cur.high_fill == '0) begin
        pop_entry = low_head_data;
        pop_send  = (cur.low_fill != '0) && (send_elapsed > TIME_W'(cfg.low_delay));
      end else begin
        pop_send = (send_elapsed > TIME_W'(cfg.high_delay))
                   || (leaked_bytes < cfg.low_limit);
      end
    end
    bytes_sum = (BYTES_W+1)'(leaked_bytes) + (BYTES_W+1)'(pop_entry.length);
  end

  // next state, ram writes and result
  always_comb begin
    nxt            = cur;
    wr             = '0;
    wr.high_addr   = high_tail;
    wr.low_addr    = low_tail;
    wr.data.handle = msg_handle;
    wr.data.length = msg_length;
    res            = '0;

    case (kind)
      KIND_TICK: begin
        nxt.now_seconds = cur.now_seconds + TIME_W'(1);
      end
      KIND_ENQ_HIGH: begin
        if (high_full) begin
          res.dropped = 1'b1;
        end else begin
          wr.high_we    = 1'b1;
          nxt.high_fill = cur.high_fill + HIGH_CW'(1);
        end
      end
      KIND_ENQ_LOW: begin
        if (low_full) begin
          res.dropped = 1'b1;
        end else begin
          wr.low_we    = 1'b1;
          nxt.low_fill = cur.low_fill + LOW_CW'(1);
        end
      end
      KIND_POP: begin
        if (leak_elapsed >= LEAK_PERIOD) begin
          nxt.leak_time = cur.now_seconds;
        end
        nxt.sent_bytes = leaked_bytes;
        if (pop_send) begin
          res.sent_valid     = 1'b1;
          res.sent_handle    = pop_entry.handle;
          res.sent_length    = pop_entry.length;
          nxt.last_send_time = cur.now_seconds;
          nxt.sent_bytes     = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];
          if (cur.high_fill == '0) begin
            nxt.low_head = (cur.low_head == LOW_AW'(LOW_DEPTH - 1))
                           ? '0 : cur.low_head + LOW_AW'(1);
            nxt.low_fill = cur.low_fill - LOW_CW'(1);
          end else begin
            nxt.high_head = (cur.high_head == HIGH_AW'(HIGH_DEPTH - 1))
                            ? '0 : cur.high_head + HIGH_AW'(1);
            nxt.high_fill = cur.high_fill - HIGH_CW'(1);
          end
        end
      end
      KIND_QUICK: begin
        if (cur.sent_bytes > cfg.quick_limit) begin
          if (high_full) begin
            res.dropped = 1'b1;
          end else begin
            wr.high_we    = 1'b1;
            nxt.high_fill = cur.high_fill + HIGH_CW'(1);
          end
        end else begin
          res.sent_valid     = 1'b1;
          res.sent_handle    = msg_handle;
          res.sent_length    = msg_length;
          nxt.last_send_time = cur.now_seconds;
        end
      end
      default: begin
      end
    endcase

    res.high_count = HCOUNT_W'(nxt.high_fill);
    res.low_count  = LCOUNT_W'(nxt.low_fill);
    res.byte_count = nxt.sent_bytes;
  end

endmodule

// ===== src/two_priority_send_queue_flood_control.sv =====
// top level of the two-priority send queue with byte-count flood control
// depends on tpsq_pkg, tpsq_ram and tpsq_policy
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event: kind, msg_handle,
//   msg_length. Kinds: one-second tick, enqueue high, enqueue low, pop,
//   quick send. Every event yields exactly one result on the output channel
//   (out_valid/out_ready): released message if any, drop flag, both queue
//   counts and the byte counter after the event.
//   Path: an accepted event is held in the input register, and the decision
//   logic carries it from the input register into the result register.
//   Throughput: one event per cycle while out_ready keeps the result slot free;
//   queue heads are read from the ring rams ahead of time using the next head
//   pointer, so a pop does not stall.
//   Configuration: cfg_write/cfg_index/cfg_data write one register per cycle;
//   the user must write only while the block is idle; the block does not enforce it.
//   Reset: both queues empty, byte counter, clock and time stamps zero,
//   registers at their defaults; no ram clearing is needed.
//   Stall: when out_ready is low the result holds, one more event waits in
//   the input register, then in_ready drops until the result is taken.

module two_priority_send_queue_flood_control import tpsq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   kind,
  input  logic [HANDLE_W-1:0] msg_handle,
  input  logic [LENGTH_W-1:0] msg_length,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                sent_valid,
  output logic [HANDLE_W-1:0] sent_handle,
  output logic [LENGTH_W-1:0] sent_length,
  output logic                dropped,
  output logic [HCOUNT_W-1:0] high_count,
  output logic [LCOUNT_W-1:0] low_count,
  output logic [BYTES_W-1:0]  byte_count,
  input  logic                cfg_write,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data
);

  logic                item_valid;
  logic [KIND_W-1:0]   item_kind;
  logic [HANDLE_W-1:0] item_handle;
  logic [LENGTH_W-1:0] item_length;
  logic                advance;

  tpsq_cfg_t    cfg;
  tpsq_state_t  state;
  tpsq_state_t  state_next;
  tpsq_wr_t     wr;
  tpsq_result_t res;
  tpsq_result_t result;

  logic [HIGH_AW-1:0] high_raddr;
  logic [LOW_AW-1:0]  low_raddr;
  logic [ENTRY_W-1:0] high_rdata;
  logic [ENTRY_W-1:0] low_rdata;
  logic               high_byp;
  logic               low_byp;
  tpsq_entry_t        byp_data;
  tpsq_entry_t        high_head_data;
  tpsq_entry_t        low_head_data;

  // handshake: the decision stage fires when an item waits and the result slot frees
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_kind   <= kind;
      item_handle <= msg_handle;
      item_length <= msg_length;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.aux_limit   <= AUX_LIMIT_RST;
      cfg.low_limit   <= LOW_LIMIT_RST;
      cfg.quick_limit <= QUICK_LIMIT_RST;
      cfg.high_delay  <= HIGH_DELAY_RST;
      cfg.low_delay   <= LOW_DELAY_RST;
      cfg.leak_bytes  <= LEAK_BYTES_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_AUX_LIMIT:   cfg.aux_limit   <= cfg_data;
        REG_LOW_LIMIT:   cfg.low_limit   <= cfg_data;
        REG_QUICK_LIMIT: cfg.quick_limit <= cfg_data;
        REG_HIGH_DELAY:  cfg.high_delay  <= cfg_data[DELAY_W-1:0];
        REG_LOW_DELAY:   cfg.low_delay   <= cfg_data[DELAY_W-1:0];
        REG_LEAK_BYTES:  cfg.leak_bytes  <= cfg_data[LEAK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // head entries: ram output, or the entry written into the head slot last cycle
  assign high_head_data = high_byp ? byp_data : tpsq_entry_t'(high_rdata);
  assign low_head_data  = low_byp ? byp_data : tpsq_entry_t'(low_rdata);

  tpsq_policy u_policy (
    .kind           (item_kind),
    .msg_handle     (item_handle),
    .msg_length     (item_length),
    .cfg            (cfg),
    .cur            (state),
    .high_head_data (high_head_data),
    .low_head_data  (low_head_data),
    .nxt            (state_next),
    .wr             (wr),
    .res            (res)
  );

  // read ahead at the head pointer that holds next cycle
  assign high_raddr = advance ? state_next.high_head : state.high_head;
  assign low_raddr  = advance ? state_next.low_head : state.low_head;

  tpsq_ram #(.WIDTH(ENTRY_W), .DEPTH(HIGH_DEPTH)) u_high_ram (
    .clk   (clk),
    .we    (advance && wr.high_we),
    .waddr (wr.high_addr),
    .wdata (wr.data),
    .raddr (high_raddr),
    .rdata (high_rdata)
  );

  tpsq_ram #(.WIDTH(ENTRY_W), .DEPTH(LOW_DEPTH)) u_low_ram (
    .clk   (clk),
    .we    (advance && wr.low_we),
    .waddr (wr.low_addr),
    .wdata (wr.data),
    .raddr (low_raddr),
    .rdata (low_rdata)
  );

  // write-to-read bypass for a push into the slot being read
  always_ff @(posedge clk) begin
    if (rst) begin
      high_byp <= 1'b0;
      low_byp  <= 1'b0;
    end else begin
      high_byp <= advance && wr.high_we && (wr.high_addr == high_raddr);
      low_byp  <= advance && wr.low_we && (wr.low_addr == low_raddr);
    end
    byp_data <= wr.data;
  end

  // queue pointers, byte counter and time stamps
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      result <= res;
    end
  end

  assign sent_valid  = result.sent_valid;
  assign sent_handle = result.sent_handle;
  assign sent_length = result.sent_length;
  assign dropped     = result.dropped;
  assign high_count  = result.high_count;
  assign low_count   = result.low_count;
  assign byte_count  = result.byte_count;

endmodule
